@@ src/cau_pkg.sv @@
// Package for the complex arithmetic unit: payload structs, command and status codes.
// Depends on nothing; used by every module of the unit.
`timescale 1ns / 1ps
package cau_pkg;
   localparam int QUOT_W = 18;

   typedef enum logic [1:0] {
      CMD_ADD = 2'd0,
      CMD_SUB = 2'd1,
      CMD_MUL = 2'd2,
      CMD_DIV = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK  = 2'd0,
      ST_SAT = 2'd1,
      ST_DBZ = 2'd2,
      ST_RSV = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]         command;
      logic signed [15:0] a_real;
      logic signed [15:0] a_imag;
      logic signed [15:0] b_real;
      logic signed [15:0] b_imag;
   } req_type;

   typedef struct packed {
      logic signed [15:0] res_real;
      logic signed [15:0] res_imag;
      logic [1:0]         status;
   } rsp_type;

   // State handed from one divider cell to the next.
   typedef struct packed {
      logic               valid;
      logic [1:0]         command;
      logic               dbz;
      logic signed [40:0] pre_real;
      logic signed [40:0] pre_imag;
      logic               neg_real;
      logic               neg_imag;
      logic [40:0]        rem_real;
      logic [40:0]        rem_imag;
      logic [32:0]        den;
      logic [QUOT_W-1:0]  quo_real;
      logic [QUOT_W-1:0]  quo_imag;
   } lane_type;

   // Saturate a wide signed value to Q8.8.
   function automatic logic [16:0] sat16(input logic signed [41:0] v);
      logic [16:0] r;
      if (v > 42'sd32767) r = {1'b1, 16'h7fff};
      else if (v < -42'sd32768) r = {1'b1, 16'h8000};
      else r = {1'b0, v[15:0]};
      return r;
   endfunction
endpackage

@@ src/cau_front.sv @@
// Front stage: products, sums and signs for every command.
// Depends on cau_pkg.
`timescale 1ns / 1ps
module cau_front import cau_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     adv,
   input  logic     in_valid,
   input  req_type  in_item,
   output lane_type out_lane
);
   logic signed [31:0] p_rr_ff, p_ii_ff, p_ir_ff, p_ri_ff, p_bb_ff, p_cc_ff;
   logic [1:0] cmd_ff;
   logic v_ff;
   logic signed [16:0] add_r_ff, add_i_ff;
   lane_type lane_in, lane_ff;

   // First register: raw products, one multiplier each, and add/sub sums.
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (adv) begin
         v_ff <= in_valid;
      end
      if (adv) begin
         cmd_ff  <= in_item.command;
         p_rr_ff <= in_item.a_real * in_item.b_real;
         p_ii_ff <= in_item.a_imag * in_item.b_imag;
         p_ir_ff <= in_item.a_imag * in_item.b_real;
         p_ri_ff <= in_item.a_real * in_item.b_imag;
         p_bb_ff <= in_item.b_real * in_item.b_real;
         p_cc_ff <= in_item.b_imag * in_item.b_imag;
         if (in_item.command == CMD_SUB) begin
            add_r_ff <= 17'(in_item.a_real) - 17'(in_item.b_real);
            add_i_ff <= 17'(in_item.a_imag) - 17'(in_item.b_imag);
         end else begin
            add_r_ff <= 17'(in_item.a_real) + 17'(in_item.b_real);
            add_i_ff <= 17'(in_item.a_imag) + 17'(in_item.b_imag);
         end
      end
   end

   // Second register: numerators, denominator and the start of the division.
   always_comb begin
      logic signed [32:0] nr, ni;
      logic signed [40:0] wr, wi;
      lane_in = '0;
      lane_in.valid = v_ff;
      lane_in.command = cmd_ff;
      lane_in.den = 33'(p_bb_ff) + 33'(p_cc_ff);
      lane_in.dbz = (lane_in.den == 33'd0);
      nr = '0;
      ni = '0;
      wr = '0;
      wi = '0;
      unique case (cmd_type'(cmd_ff))
         CMD_ADD, CMD_SUB: begin
            lane_in.pre_real = 41'(add_r_ff);
            lane_in.pre_imag = 41'(add_i_ff);
         end
         CMD_MUL: begin
            nr = 33'(p_rr_ff) - 33'(p_ii_ff);
            ni = 33'(p_ir_ff) + 33'(p_ri_ff);
            // Division by 256 truncating toward zero.
            lane_in.pre_real = 41'((nr + (nr[32] ? 33'sd255 : 33'sd0)) >>> 8);
            lane_in.pre_imag = 41'((ni + (ni[32] ? 33'sd255 : 33'sd0)) >>> 8);
         end
         CMD_DIV: begin
            nr = 33'(p_rr_ff) + 33'(p_ii_ff);
            ni = 33'(p_ir_ff) - 33'(p_ri_ff);
            wr = 41'(nr) <<< 8;
            wi = 41'(ni) <<< 8;
            lane_in.neg_real = wr[40];
            lane_in.neg_imag = wi[40];
            lane_in.rem_real = wr[40] ? 41'(-wr) : wr;
            lane_in.rem_imag = wi[40] ? 41'(-wi) : wi;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_ff.valid <= 1'b0;
      end else if (adv) begin
         lane_ff <= lane_in;
      end
   end

   assign out_lane = lane_ff;
endmodule

@@ src/cau_cell.sv @@
// One restoring-division cell: produces one quotient bit per lane and passes on.
// Depends on cau_pkg.
`timescale 1ns / 1ps
module cau_cell import cau_pkg::*; #(
   parameter int BIT = 0
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     adv,
   input  lane_type in_lane,
   output lane_type out_lane
);
   lane_type lane_in, lane_ff;

   // Compare the remainder against the shifted divisor for this bit weight.
   always_comb begin
      logic [73:0] sh;
      sh = 74'(in_lane.den) << BIT;
      lane_in = in_lane;
      if (in_lane.command == CMD_DIV) begin
         if (74'(in_lane.rem_real) >= sh) begin
            lane_in.rem_real = 41'(74'(in_lane.rem_real) - sh);
            lane_in.quo_real[BIT] = 1'b1;
         end
         if (74'(in_lane.rem_imag) >= sh) begin
            lane_in.rem_imag = 41'(74'(in_lane.rem_imag) - sh);
            lane_in.quo_imag[BIT] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_ff.valid <= 1'b0;
      end else if (adv) begin
         lane_ff <= lane_in;
      end
   end

   assign out_lane = lane_ff;
endmodule

@@ src/complex_arith_unit.sv @@
// Complex arithmetic unit, Q8.8: add, subtract, multiply, divide with saturation.
// One transfer is accepted every cycle while no stalled response holds the chain.
// The divider is a chain of QUOT_W cells, one quotient bit per cell.
// A valid output register is held while rsp_stall is high and stalls the chain.
// Synchronous active-high reset clears all valid bits; payloads are not reset.
`timescale 1ns / 1ps
module complex_arith_unit import cau_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);
   lane_type chain [QUOT_W+1];
   logic adv;
   logic rv_ff;
   rsp_type rd_ff, rd_in;

   assign adv = !(rv_ff && rsp_stall);
   assign req_stall = !adv;

   cau_front u_front (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(req_valid), .in_item(req_data), .out_lane(chain[0])
   );

   // Most significant quotient bit first.
   for (genvar g = 0; g < QUOT_W; g++) begin : g_cell
      cau_cell #(.BIT(QUOT_W - 1 - g)) u_cell (
         .clock(clock), .reset(reset), .adv(adv),
         .in_lane(chain[g]), .out_lane(chain[g+1])
      );
   end

   // Final signs, saturation and status.
   always_comb begin
      lane_type l;
      logic signed [41:0] vr, vi;
      logic [16:0] sr, si;
      l = chain[QUOT_W];
      if (l.command == CMD_DIV) begin
         vr = l.neg_real ? -42'(l.quo_real) : 42'(l.quo_real);
         vi = l.neg_imag ? -42'(l.quo_imag) : 42'(l.quo_imag);
      end else begin
         vr = 42'(l.pre_real);
         vi = 42'(l.pre_imag);
      end
      sr = sat16(vr);
      si = sat16(vi);
      if (l.command == CMD_DIV && l.dbz) begin
         rd_in.res_real = '0;
         rd_in.res_imag = '0;
         rd_in.status = ST_DBZ;
      end else begin
         rd_in.res_real = sr[15:0];
         rd_in.res_imag = si[15:0];
         rd_in.status = (sr[16] || si[16]) ? ST_SAT : ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else if (adv) begin
         rv_ff <= chain[QUOT_W].valid;
      end
      if (adv) begin
         rd_ff <= rd_in;
      end
   end

   assign rsp_valid = rv_ff;
   assign rsp_data = rd_ff;
endmodule

@@ src/cau_checker.sv @@
// Port-level checks for the complex arithmetic unit, bound to the top level.
// Depends on cau_pkg and complex_arith_unit.
`timescale 1ns / 1ps
module cau_checker import cau_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");
   a_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("request stall not from response stall");
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status != ST_RSV)
      else $error("reserved status");
   a_dbz: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_DBZ |-> rsp_data.res_real == 16'd0
      && rsp_data.res_imag == 16'd0)
      else $error("divide by zero with non-zero result");
endmodule

bind complex_arith_unit cau_checker u_cau_checker (
   .clock(clock), .reset(reset), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
);

@@ dv/complex_arith_unit_test.sv @@
// Self-checking testbench for the complex arithmetic unit: add, subtract, multiply, divide.
// Depends on cau_pkg and complex_arith_unit; a scoreboard class predicts every result.
`timescale 1ns / 1ps
module complex_arith_unit_test;
   import cau_pkg::*;

   // Predicts the result of each accepted transfer and checks results in order.
   class cau_scoreboard;
      rsp_type pending[$];
      int errors;

      function new();
         errors = 0;
      endfunction

      function void note_request(req_type r);
         longint ar, ai, br, bi, re, im, den;
         logic sat;
         rsp_type p;
         ar = r.a_real;
         ai = r.a_imag;
         br = r.b_real;
         bi = r.b_imag;
         re = 0;
         im = 0;
         sat = 1'b0;
         p.status = ST_OK;
         case (cmd_type'(r.command))
            CMD_ADD: begin
               re = ar + br;
               im = ai + bi;
            end
            CMD_SUB: begin
               re = ar - br;
               im = ai - bi;
            end
            CMD_MUL: begin
               re = (ar * br - ai * bi) / 256;
               im = (ai * br + ar * bi) / 256;
            end
            default: begin
               den = br * br + bi * bi;
               if (den == 0) begin
                  p.status = ST_DBZ;
               end else begin
                  re = ((ar * br + ai * bi) * 256) / den;
                  im = ((ai * br - ar * bi) * 256) / den;
               end
            end
         endcase
         if (p.status != ST_DBZ) begin
            if (re > 32767) begin re = 32767; sat = 1'b1; end
            if (re < -32768) begin re = -32768; sat = 1'b1; end
            if (im > 32767) begin im = 32767; sat = 1'b1; end
            if (im < -32768) begin im = -32768; sat = 1'b1; end
            p.status = sat ? ST_SAT : ST_OK;
         end
         p.res_real = re[15:0];
         p.res_imag = im[15:0];
         pending.push_back(p);
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            $error("result transfer with no request outstanding");
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.res_real !== want.res_real) begin
            $error("res_real expected %0d actual %0d", want.res_real, got.res_real);
            errors++;
         end
         if (got.res_imag !== want.res_imag) begin
            $error("res_imag expected %0d actual %0d", want.res_imag, got.res_imag);
            errors++;
         end
         if (got.status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, got.status);
            errors++;
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   cau_scoreboard board;
   int send_idle_pct;
   int recv_idle_pct;
   logic hold_off;
   int quiet_cycles;

   complex_arith_unit u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Picks an operand part, often at an edge of the range.
   function automatic logic [15:0] pick_part();
      case ($urandom_range(0, 7))
         0: return 16'h7fff;
         1: return 16'h8000;
         2: return 16'h0000;
         3: return 16'(int'($urandom_range(0, 512)) - 256);
         4: return 16'(int'($urandom_range(0, 8)) - 4);
         default: return 16'($urandom);
      endcase
   endfunction

   // Offers one transfer and waits until it is accepted; valid stays high afterwards
   // so that the next transfer can follow without a gap.
   task automatic send_request(input logic [1:0] cmd, input logic [15:0] ar,
                               input logic [15:0] ai, input logic [15:0] br,
                               input logic [15:0] bi);
      req_type r;
      r.command = cmd;
      r.a_real = ar;
      r.a_imag = ai;
      r.b_real = br;
      r.b_imag = bi;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(r);
   endtask

   task automatic send_random(input int n);
      logic [1:0] cmd;
      for (int i = 0; i < n; i++) begin
         cmd = 2'($urandom_range(0, 3));
         if (cmd == CMD_DIV && $urandom_range(0, 19) == 0)
            send_request(cmd, pick_part(), pick_part(), 16'h0000, 16'h0000);
         else
            send_request(cmd, pick_part(), pick_part(), pick_part(), pick_part());
      end
   endtask

   // The receiver stalls at random, or for a long stretch when asked.
   always @(posedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= hold_off || ($urandom_range(0, 99) < recv_idle_pct);
   end

   // Each result transfer is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_result(rsp_data);
   end

   // Watchdog on cycles with no transfer on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 5000) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      board = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      hold_off = 1'b0;
      send_idle_pct = 9;
      recv_idle_pct = 55;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed transfers: range edges, every command, saturation, divide by zero.
      send_request(CMD_ADD, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
      send_request(CMD_ADD, 16'h0100, 16'hff00, 16'h0080, 16'h0001);
      send_request(CMD_SUB, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
      send_request(CMD_SUB, 16'h0000, 16'h0000, 16'hffff, 16'h0001);
      send_request(CMD_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_request(CMD_MUL, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000);
      send_request(CMD_MUL, 16'h0100, 16'h0000, 16'h0100, 16'h0000);
      send_request(CMD_MUL, 16'hffff, 16'h0001, 16'h0001, 16'h0001);
      send_request(CMD_DIV, 16'h0100, 16'h0100, 16'h0000, 16'h0000);
      send_request(CMD_DIV, 16'h8000, 16'h7fff, 16'h0000, 16'h0000);
      send_request(CMD_DIV, 16'h7fff, 16'h7fff, 16'h0001, 16'h0000);
      send_request(CMD_DIV, 16'h8000, 16'h8000, 16'h0000, 16'hffff);
      send_request(CMD_DIV, 16'h0100, 16'h0000, 16'h0100, 16'h0000);
      send_request(CMD_DIV, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_request(CMD_DIV, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff);
      send_request(CMD_DIV, 16'hffff, 16'h0001, 16'h0003, 16'hfffd);

      send_random(300);

      // Long hold-off on the result side while transfers keep being offered.
      fork
         begin
            hold_off = 1'b1;
            repeat (200) @(posedge clock);
            hold_off = 1'b0;
         end
         send_random(60);
      join

      send_idle_pct = 55;
      recv_idle_pct = 9;
      send_random(320);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_random(320);
      req_valid <= 1'b0;

      while (board.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end
endmodule
